// ===== rtl/snts_pkg.sv =====
// shared types, constants and step tables for the stepper note tone sequencer
`default_nettype none
package snts_pkg;

  localparam int NUM_CHANNELS = 8;
  // chan and out_chan are 3 bits, so at most eight channels are reachable
  localparam int LIVE_CH = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int CMD_W = 2;
  localparam int CHAN_W = 3;
  localparam int NOTE_W = 7;
  localparam int PERIOD_W = 16;
  localparam int COIL_W = 4;
  localparam int MODE_W = 2;
  localparam int PHASE_W = 3;
  localparam int TOTAL_W = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_STOP_ALL = 2'd3
  } cmd_t;

  localparam logic [MODE_W-1:0] MODE_WAVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_LAST4 = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_LAST8 = 3'd7;

  localparam logic [COIL_W-1:0] WAVE_SEQ [4] = '{4'h1, 4'h4, 4'h2, 4'h8};
  localparam logic [COIL_W-1:0] FULL_SEQ [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
  localparam logic [COIL_W-1:0] HALF_SEQ [8] =
    '{4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9};

  typedef enum logic [1:0] {
    S_IDLE,
    S_EX,
    S_FIN
  } state_t;

  // one channel's stored state, one memory word
  typedef struct packed {
    logic                active;
    logic [NOTE_W-1:0]   note;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] count;
    logic [PHASE_W-1:0]  phase;
  } entry_t;

  typedef struct packed {
    logic               res;
    logic [COIL_W-1:0]  coils;
    logic               inc;
    logic               dec;
    entry_t             nxt;
  } upd_t;

  function automatic logic [COIL_W-1:0] step_pattern(logic [MODE_W-1:0] mode,
                                                     logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (mode)
      MODE_HALF: pat = HALF_SEQ[ph];
      MODE_FULL: pat = FULL_SEQ[ph[1:0]];
      default:   pat = WAVE_SEQ[ph[1:0]];
    endcase
    return pat;
  endfunction

  function automatic logic [PHASE_W-1:0] step_advance(logic [MODE_W-1:0] mode,
                                                      logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] lim;
    lim = (mode == MODE_HALF) ? PHASE_LAST8 : PHASE_LAST4;
    return (ph >= lim) ? '0 : PHASE_W'(ph + 1'b1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/snts_ifs.sv =====
// handshake channel interfaces: commands, coil updates, step mode writes
`default_nettype none
interface snts_cmd_if;
  import snts_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [CHAN_W-1:0]   chan;
  logic [NOTE_W-1:0]   note;
  logic [PERIOD_W-1:0] period;
  modport source (output valid, cmd, chan, note, period, input ready);
  modport sink (input valid, cmd, chan, note, period, output ready);
endinterface

interface snts_coil_if;
  import snts_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_chan;
  logic [COIL_W-1:0] coils;
  logic              last;
  modport source (output valid, out_chan, coils, last, input ready);
  modport sink (input valid, out_chan, coils, last, output ready);
endinterface

interface snts_cfg_if;
  import snts_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] step_mode;
  modport source (output valid, step_mode, input ready);
  modport sink (input valid, step_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/snts_ram.sv =====
// generic single write, single registered read ram
`default_nettype none
module snts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/snts_update.sv =====
// per-channel read-modify-write logic for one command
`default_nettype none
module snts_update (
  input  wire logic [snts_pkg::CMD_W-1:0]    cmd,
  input  wire logic [snts_pkg::NOTE_W-1:0]   note,
  input  wire logic [snts_pkg::PERIOD_W-1:0] period,
  input  wire logic [snts_pkg::MODE_W-1:0]   mode,
  input  wire snts_pkg::entry_t              cur,
  output snts_pkg::upd_t                     upd
);
  import snts_pkg::*;

  always_comb begin
    upd = '0;
    upd.nxt = cur;
    case (cmd_t'(cmd))
      CMD_TICK: begin
        if (cur.period != '0) begin
          if (cur.count >= cur.period) begin
            upd.res = 1'b1;
            upd.coils = step_pattern(mode, cur.phase);
            upd.nxt.count = '0;
            upd.nxt.phase = step_advance(mode, cur.phase);
          end else begin
            upd.nxt.count = PERIOD_W'(cur.count + 1'b1);
          end
        end
      end
      CMD_NOTE_ON: begin
        // busy channel keeps its note
        if (!cur.active) begin
          upd.nxt.active = 1'b1;
          upd.nxt.note = note;
          upd.nxt.period = period;
          upd.inc = 1'b1;
        end
      end
      CMD_NOTE_OFF: begin
        if (cur.active && cur.note == note) begin
          upd.nxt.active = 1'b0;
          upd.nxt.note = '0;
          upd.nxt.period = '0;
          upd.res = 1'b1;
          upd.dec = 1'b1;
        end
      end
      CMD_STOP_ALL: begin
        // phase survives
        upd.nxt.active = 1'b0;
        upd.nxt.note = '0;
        upd.nxt.period = '0;
        upd.nxt.count = '0;
        upd.res = 1'b1;
      end
      default: begin
        upd.nxt = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/stepper_note_tone_sequencer.sv =====
// top level: stepper note tone sequencer with channel state in ram
//
//   port   dir   carries                              accepted when
//   req    sink  cmd, chan, note, period              req.valid && req.ready
//   rsp    src   out_chan, coils, last                rsp.valid && rsp.ready
//   cfg    sink  step_mode                            cfg.valid && cfg.ready
//
// one command at a time. tick and stop_all walk the channels, one channel per
// cycle through the ram read/write pipe, unless a held update waits on the output.
// note_on and note_off touch one channel. a tick with no active note is taken without a walk.
// a coil update is held back one step so last can be set on the final one.
// rst is synchronous; per-channel valid bits make the ram read as zero after it.
`default_nettype none
module stepper_note_tone_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  snts_cmd_if.sink  req,
  snts_coil_if.source rsp,
  snts_cfg_if.sink  cfg
);
  import snts_pkg::*;

  state_t              state, state_next;
  logic [CMD_W-1:0]    cmd_q;
  logic [NOTE_W-1:0]   note_q;
  logic [PERIOD_W-1:0] period_q;
  logic [CH_W-1:0]     idx, end_idx;
  logic [TOTAL_W-1:0]  active_total;
  logic [MODE_W-1:0]   step_mode;

  logic                pend_v;
  logic [CHAN_W-1:0]   pend_chan;
  logic [COIL_W-1:0]   pend_coils;

  logic [NUM_CHANNELS-1:0] vld;
  logic                rd_vld;
  logic [CH_W-1:0]     rd_addr;
  logic [$bits(entry_t)-1:0] rd_data;
  entry_t              cur;
  upd_t                upd;

  logic in_acc, out_free, go, in_range, scan_all;
  logic proceed, wr_en, out_load, out_last, pend_clr;

  assign in_acc = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign scan_all = (req.cmd == CMD_TICK) || (req.cmd == CMD_STOP_ALL);
  assign in_range = 32'(req.chan) < LIVE_CH;
  assign cur = rd_vld ? entry_t'(rd_data) : '0;
  assign cfg.ready = 1'b1;

  always_comb begin
    case (cmd_t'(req.cmd))
      CMD_TICK:     go = active_total != '0;
      CMD_STOP_ALL: go = 1'b1;
      default:      go = in_range;
    endcase
  end

  snts_update u_update (
    .cmd    (cmd_q),
    .note   (note_q),
    .period (period_q),
    .mode   (step_mode),
    .cur    (cur),
    .upd    (upd)
  );

  snts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (upd.nxt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    req.ready = 1'b0;
    rd_addr = idx;
    proceed = 1'b0;
    wr_en = 1'b0;
    out_load = 1'b0;
    out_last = 1'b0;
    pend_clr = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        rd_addr = scan_all ? '0 : CH_W'(req.chan);
        if (in_acc && go) begin
          state_next = S_EX;
        end
      end
      S_EX: begin
        // a new update with one still held needs the output register free
        proceed = !(upd.res && pend_v && !out_free);
        if (proceed) begin
          wr_en = 1'b1;
          rd_addr = CH_W'(idx + 1'b1);
          out_load = upd.res && pend_v;
          if (idx == end_idx) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!pend_v) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          pend_clr = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active_total <= '0;
      step_mode <= MODE_WAVE;
      pend_v <= 1'b0;
      vld <= '0;
      rd_vld <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_vld <= vld[rd_addr];
      if (wr_en) begin
        vld[idx] <= 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        step_mode <= cfg.step_mode;
      end
      if (in_acc && req.cmd == CMD_STOP_ALL) begin
        active_total <= '0;
      end else if (proceed && upd.inc && active_total != TOTAL_MAX) begin
        active_total <= TOTAL_W'(active_total + 1'b1);
      end else if (proceed && upd.dec && active_total != '0) begin
        active_total <= TOTAL_W'(active_total - 1'b1);
      end
      if (proceed && upd.res) begin
        pend_v <= 1'b1;
      end else if (pend_clr) begin
        pend_v <= 1'b0;
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q <= req.cmd;
      note_q <= req.note;
      period_q <= req.period;
      idx <= scan_all ? '0 : CH_W'(req.chan);
      end_idx <= scan_all ? CH_W'(LIVE_CH - 1) : CH_W'(req.chan);
    end else if (proceed) begin
      idx <= CH_W'(idx + 1'b1);
    end
    if (proceed && upd.res) begin
      pend_chan <= CHAN_W'(idx);
      pend_coils <= upd.coils;
    end
    if (out_load) begin
      rsp.out_chan <= pend_chan;
      rsp.coils <= pend_coils;
      rsp.last <= out_last;
    end
  end

endmodule
`default_nettype wire
